// File: rtl/core/repeat_wrap_nearest_texture_sampler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the texture sampler.
// Clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REPEAT_WRAP_NEAREST_TEXTURE_SAMPLER_ASSERT_SVH
`define REPEAT_WRAP_NEAREST_TEXTURE_SAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWNTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RWNTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rwnts_pkg.sv
// ----------------------------------------------------------------------------
// rwnts_pkg
// Types, constants and helper functions for the texture sampler.
// ----------------------------------------------------------------------------
package rwnts_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int WRAP_W    = FRAC_W + 1;
  localparam int BYTE_W    = 8;
  localparam int TEXEL_W   = 3 * BYTE_W;
  localparam int POS_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = 9'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [COORD_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef logic [TEXEL_W-1:0] texel_t;
  typedef logic [WRAP_W-1:0]  wrap_t;

  // Folds a signed Q16.16 coordinate into [0, 1.0] as unsigned Q1.16.
  function automatic wrap_t wrap_coord(input logic [COORD_W-1:0] c);
    wrap_t w;
    if (c[COORD_W-1]) begin
      w = {1'b0, c[FRAC_W-1:0]};
    end else if (c > ONE_Q16) begin
      w = {1'b0, c[FRAC_W-1:0]};
    end else begin
      w = c[WRAP_W-1:0];
    end
    return w;
  endfunction

endpackage

// File: rtl/core/rwnts_ifs.sv
// ----------------------------------------------------------------------------
// rwnts_in_if / rwnts_out_if
// Valid/ready channels for sampler requests and sampled texels.
// ----------------------------------------------------------------------------
interface rwnts_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [rwnts_pkg::POS_W-1:0]        texel_x;
  logic [rwnts_pkg::POS_W-1:0]        texel_y;
  logic [rwnts_pkg::BYTE_W-1:0]       red_in;
  logic [rwnts_pkg::BYTE_W-1:0]       green_in;
  logic [rwnts_pkg::BYTE_W-1:0]       blue_in;
  logic signed [rwnts_pkg::COORD_W-1:0] coord_u;
  logic signed [rwnts_pkg::COORD_W-1:0] coord_v;

  modport source (output valid, action, texel_x, texel_y, red_in, green_in, blue_in,
                  coord_u, coord_v, input ready);
  modport sink (input valid, action, texel_x, texel_y, red_in, green_in, blue_in,
                coord_u, coord_v, output ready);
endinterface

interface rwnts_out_if;
  logic                         valid;
  logic                         ready;
  logic [rwnts_pkg::BYTE_W-1:0] red_out;
  logic [rwnts_pkg::BYTE_W-1:0] green_out;
  logic [rwnts_pkg::BYTE_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

// File: rtl/core/repeat_wrap_nearest_texture_sampler.sv
// A texel write is done in idle. A sample is wrapped on transfer, scaled in the
// multiply state, read from the texture store in the read state and loaded into
// the output register in the done state; no request is taken until then.
// The output register lets a new item in while a result waits to be taken.
// Reset clears the sequencer and output valid and sets both sizes to 64;
// the texture store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// repeat_wrap_nearest_texture_sampler
// Nearest texel lookup with repeat wrapping over a single-port texture store.
// ----------------------------------------------------------------------------
`include "repeat_wrap_nearest_texture_sampler_assert.svh"

module repeat_wrap_nearest_texture_sampler #(
  parameter int MAX_WIDTH  = rwnts_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rwnts_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rwnts_in_if.sink                             in_ch,
  rwnts_out_if.source                          out_ch,
  input  logic                                 cfg_we,
  input  logic [rwnts_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [rwnts_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int SZW_W  = $clog2(MAX_WIDTH + 1);
  localparam int SZH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int PU_W   = SZW_W + rwnts_pkg::WRAP_W;
  localparam int PV_W   = SZH_W + rwnts_pkg::WRAP_W;
  localparam int FW     = rwnts_pkg::FRAC_W;
  localparam int BW     = rwnts_pkg::BYTE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [rwnts_pkg::CFG_DATA_W-1:0] tex_w_r, tex_h_r;

  rwnts_pkg::wrap_t u_wrap_r, v_wrap_r;
  logic [SZW_W-1:0] w_eff_r, w_eff;
  logic [SZH_W-1:0] h_eff_r, h_eff;
  logic [PU_W-1:0]  prod_u_r, prod_u_nxt;
  logic [PV_W-1:0]  prod_v_r, prod_v_nxt;

  logic [SZW_W:0]   idx_u, lim_u, col_full;
  logic [SZH_W:0]   idx_v, lim_v, row_full;
  logic [COL_W-1:0] col_idx, wr_col;
  logic [ROW_W-1:0] row_idx, wr_row;

  rwnts_pkg::texel_t mem_r [0:(1 << ADDR_W)-1];
  rwnts_pkg::texel_t rdata_r, out_data_r;
  logic              out_valid_r;

  logic in_xfer, out_xfer, mem_we, out_load;
  logic in_smp, in_wr;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_smp      = in_xfer && (in_ch.action == rwnts_pkg::ACT_SAMPLE);
  assign in_wr       = in_xfer && (in_ch.action == rwnts_pkg::ACT_WRITE);
  assign out_xfer    = out_ch.valid && out_ch.ready;
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r <= rwnts_pkg::CFG_SIZE_RESET;
      tex_h_r <= rwnts_pkg::CFG_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rwnts_pkg::CFG_IDX_WIDTH:  tex_w_r <= cfg_wdata;
        rwnts_pkg::CFG_IDX_HEIGHT: tex_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tex_w_r == '0) begin
      w_eff = SZW_W'(1);
    end else if (32'(tex_w_r) > MAX_WIDTH) begin
      w_eff = SZW_W'(MAX_WIDTH);
    end else begin
      w_eff = SZW_W'(tex_w_r);
    end
    if (tex_h_r == '0) begin
      h_eff = SZH_W'(1);
    end else if (32'(tex_h_r) > MAX_HEIGHT) begin
      h_eff = SZH_W'(MAX_HEIGHT);
    end else begin
      h_eff = SZH_W'(tex_h_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_smp) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      u_wrap_r <= rwnts_pkg::wrap_coord(in_ch.coord_u);
      v_wrap_r <= rwnts_pkg::wrap_coord(in_ch.coord_v);
      w_eff_r  <= w_eff;
      h_eff_r  <= h_eff;
    end
  end

  assign prod_u_nxt = {{rwnts_pkg::WRAP_W{1'b0}}, w_eff_r} * {{SZW_W{1'b0}}, u_wrap_r};
  assign prod_v_nxt = {{rwnts_pkg::WRAP_W{1'b0}}, h_eff_r} * {{SZH_W{1'b0}}, v_wrap_r};

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_u_r <= prod_u_nxt;
      prod_v_r <= prod_v_nxt;
    end
  end

  assign idx_u    = prod_u_r[PU_W-1:FW];
  assign idx_v    = prod_v_r[PV_W-1:FW];
  assign lim_u    = {1'b0, w_eff_r} - (SZW_W + 1)'(1);
  assign lim_v    = {1'b0, h_eff_r} - (SZH_W + 1)'(1);
  assign col_full = (idx_u > lim_u) ? lim_u : idx_u;
  assign row_full = (idx_v > lim_v) ? lim_v : idx_v;
  assign col_idx  = col_full[COL_W-1:0];
  assign row_idx  = row_full[ROW_W-1:0];

  assign wr_col = COL_W'(in_ch.texel_x);
  assign wr_row = ROW_W'(in_ch.texel_y);
  assign mem_we = in_wr
                  && (32'(in_ch.texel_x) < MAX_WIDTH) && (32'(in_ch.texel_y) < MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[{wr_row, wr_col}] <= {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      rdata_r <= mem_r[{row_idx, col_idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= rdata_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = out_data_r[3*BW-1:2*BW];
  assign out_ch.green_out = out_data_r[2*BW-1:BW];
  assign out_ch.blue_out  = out_data_r[BW-1:0];

  `RWNTS_ASSERT_NEXT(a_sample_starts_mul, in_smp, state_r == ST_MUL, "Sample skipped multiply.")
  `RWNTS_ASSERT_NEXT(a_write_stays_idle, in_wr, state_r == ST_IDLE, "Texel write left idle.")
  `RWNTS_ASSERT_SAME(a_vld_done, $rose(out_valid_r), $past(state_r) == ST_DONE, "Early valid.")
  `RWNTS_ASSERT_SAME(a_col_range, state_r == ST_RD, col_full <= lim_u, "Bad column.")
  `RWNTS_ASSERT_SAME(a_row_range, state_r == ST_RD, row_full <= lim_v, "Bad row.")

endmodule

// File: verif/repeat_wrap_nearest_texture_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeat_wrap_nearest_texture_sampler_tb
// Self-checking bench for the repeat-wrap nearest texel sampler. Texel writes
// and samples are streamed over the valid/ready input channel while the
// texture sizes are stepped through several settings. A scoreboard mirrors
// the texture store and the coordinate wrapping, and checks each returned
// texel in order. Samples only ever target texels written beforehand.
// ----------------------------------------------------------------------------
module repeat_wrap_nearest_texture_sampler_tb;

  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 10;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASE_ITEMS = 90;
  localparam int XY_W        = rwnts_pkg::POS_W;
  localparam int CFG_W       = rwnts_pkg::CFG_DATA_W;
  localparam int STORE_DEPTH = rwnts_pkg::DEF_MAX_WIDTH * rwnts_pkg::DEF_MAX_HEIGHT;

  typedef struct {
    logic                             action;
    logic [rwnts_pkg::POS_W-1:0]      x;
    logic [rwnts_pkg::POS_W-1:0]      y;
    rwnts_pkg::texel_t                rgb;
    logic [rwnts_pkg::COORD_W-1:0]    u;
    logic [rwnts_pkg::COORD_W-1:0]    v;
  } texel_request_t;

  class texel_lookup_board;
    rwnts_pkg::texel_t                texel_mem [0:STORE_DEPTH-1];
    rwnts_pkg::texel_t                expected_texels [$];
    logic [rwnts_pkg::CFG_DATA_W-1:0] width_reg;
    logic [rwnts_pkg::CFG_DATA_W-1:0] height_reg;
    int                               errors;

    function new();
      width_reg  = rwnts_pkg::CFG_SIZE_RESET;
      height_reg = rwnts_pkg::CFG_SIZE_RESET;
      errors     = 0;
    endfunction

    static function int effective(logic [rwnts_pkg::CFG_DATA_W-1:0] size_reg, int limit);
      if (size_reg == 0) return 1;
      if (size_reg > limit) return limit;
      return int'(size_reg);
    endfunction

    static function int nearest_index(logic [rwnts_pkg::COORD_W-1:0] c,
                                      logic [rwnts_pkg::CFG_DATA_W-1:0] size_reg,
                                      int limit);
      logic [rwnts_pkg::WRAP_W-1:0] w;
      int                           size;
      longint                       prod;
      int                           idx;
      size = effective(size_reg, limit);
      if (c[rwnts_pkg::COORD_W-1] || c > rwnts_pkg::ONE_Q16) begin
        w = {1'b0, c[rwnts_pkg::FRAC_W-1:0]};
      end else begin
        w = c[rwnts_pkg::WRAP_W-1:0];
      end
      prod = longint'(size) * longint'(w);
      idx  = int'(prod >> rwnts_pkg::FRAC_W);
      if (idx > size - 1) idx = size - 1;
      return idx;
    endfunction

    function int texel_addr(logic [rwnts_pkg::COORD_W-1:0] u,
                            logic [rwnts_pkg::COORD_W-1:0] v);
      int col;
      int row;
      col = nearest_index(u, width_reg, rwnts_pkg::DEF_MAX_WIDTH);
      row = nearest_index(v, height_reg, rwnts_pkg::DEF_MAX_HEIGHT);
      return row * rwnts_pkg::DEF_MAX_WIDTH + col;
    endfunction

    function void set_size(logic [rwnts_pkg::CFG_IDX_W-1:0] idx,
                           logic [rwnts_pkg::CFG_DATA_W-1:0] val);
      if (idx == rwnts_pkg::CFG_IDX_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function int pending();
      return expected_texels.size();
    endfunction

    function void note_transfer(texel_request_t r);
      if (r.action == rwnts_pkg::ACT_WRITE) begin
        texel_mem[{r.y, r.x}] = r.rgb;
      end else begin
        expected_texels.push_back(texel_mem[texel_addr(r.u, r.v)]);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task check_texel(logic [rwnts_pkg::BYTE_W-1:0] r, logic [rwnts_pkg::BYTE_W-1:0] g,
                     logic [rwnts_pkg::BYTE_W-1:0] b);
      rwnts_pkg::texel_t want;
      if (expected_texels.size() == 0) begin
        report($sformatf("texel %h%h%h returned with no sample pending", r, g, b));
      end else begin
        want = expected_texels.pop_front();
        if (r !== want[23:16])
          report($sformatf("red got %h, expected %h", r, want[23:16]));
        if (g !== want[15:8])
          report($sformatf("green got %h, expected %h", g, want[15:8]));
        if (b !== want[7:0])
          report($sformatf("blue got %h, expected %h", b, want[7:0]));
      end
    endtask
  endclass

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_we;
  logic [rwnts_pkg::CFG_IDX_W-1:0]    cfg_idx;
  logic [rwnts_pkg::CFG_DATA_W-1:0]   cfg_wdata;
  bit                                 calm;
  bit                                 hold_go;
  bit                                 written [0:STORE_DEPTH-1];
  texel_lookup_board                  board = new();

  rwnts_in_if  in_ch ();
  rwnts_out_if out_ch ();

  repeat_wrap_nearest_texture_sampler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic push_item(texel_request_t r);
    if (!calm && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= r.action;
    in_ch.texel_x  <= r.x;
    in_ch.texel_y  <= r.y;
    in_ch.red_in   <= r.rgb[23:16];
    in_ch.green_in <= r.rgb[15:8];
    in_ch.blue_in  <= r.rgb[7:0];
    in_ch.coord_u  <= r.u;
    in_ch.coord_v  <= r.v;
    do @(posedge clk); while (!in_ch.ready);
    board.note_transfer(r);
  endtask

  task automatic put_texel(int x, int y, rwnts_pkg::texel_t rgb);
    texel_request_t r;
    r.action = rwnts_pkg::ACT_WRITE;
    r.x      = x[XY_W-1:0];
    r.y      = y[XY_W-1:0];
    r.rgb    = rgb;
    r.u      = $urandom;
    r.v      = $urandom;
    written[{r.y, r.x}] = 1'b1;
    push_item(r);
  endtask

  task automatic sample_at(logic [rwnts_pkg::COORD_W-1:0] u,
                           logic [rwnts_pkg::COORD_W-1:0] v);
    texel_request_t r;
    int             addr;
    addr = board.texel_addr(u, v);
    if (!written[addr]) begin
      put_texel(addr % rwnts_pkg::DEF_MAX_WIDTH, addr / rwnts_pkg::DEF_MAX_WIDTH,
                rwnts_pkg::texel_t'($urandom));
    end
    r.action = rwnts_pkg::ACT_SAMPLE;
    r.x      = XY_W'($urandom);
    r.y      = XY_W'($urandom);
    r.rgb    = rwnts_pkg::texel_t'($urandom);
    r.u      = u;
    r.v      = v;
    push_item(r);
  endtask

  function automatic logic [rwnts_pkg::COORD_W-1:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 6 * 65536) - 3 * 65536;
      2: return ($urandom_range(0, 6) - 3) * 65536;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  task automatic run_phase(int count);
    int w;
    int h;
    w = texel_lookup_board::effective(board.width_reg, rwnts_pkg::DEF_MAX_WIDTH);
    h = texel_lookup_board::effective(board.height_reg, rwnts_pkg::DEF_MAX_HEIGHT);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 35) begin
        if ($urandom_range(99) < 70) begin
          put_texel($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                    rwnts_pkg::texel_t'($urandom));
        end else begin
          put_texel($urandom_range(0, 255), $urandom_range(0, 255),
                    rwnts_pkg::texel_t'($urandom));
        end
      end else begin
        sample_at(pick_coord(), pick_coord());
      end
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_sizes(logic [rwnts_pkg::CFG_DATA_W-1:0] w,
                           logic [rwnts_pkg::CFG_DATA_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_idx   <= rwnts_pkg::CFG_IDX_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    board.set_size(rwnts_pkg::CFG_IDX_WIDTH, w);
    cfg_idx   <= rwnts_pkg::CFG_IDX_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    board.set_size(rwnts_pkg::CFG_IDX_HEIGHT, h);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= rst_n && (calm || $urandom_range(99) >= 23);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_texel(out_ch.red_out, out_ch.green_out, out_ch.blue_out);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("repeat_wrap_nearest_texture_sampler_tb NOT OK");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = rwnts_pkg::CFG_IDX_WIDTH;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.action   = rwnts_pkg::ACT_WRITE;
    in_ch.texel_x  = '0;
    in_ch.texel_y  = '0;
    in_ch.red_in   = '0;
    in_ch.green_in = '0;
    in_ch.blue_in  = '0;
    in_ch.coord_u  = '0;
    in_ch.coord_v  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Corner coordinates at the reset sizes, including the top edge at 1.0.
    put_texel(0, 0, 24'h000000);
    put_texel(255, 255, 24'hFFFFFF);
    put_texel(255, 0, 24'hFF00FF);
    put_texel(0, 255, 24'h00FF00);
    put_texel(63, 63, 24'hA55AC3);
    sample_at(32'h0000_0000, 32'h0000_0000);
    sample_at(32'h0001_0000, 32'h0001_0000);
    sample_at(32'h7FFF_FFFF, 32'h8000_0000);
    sample_at(32'hFFFF_FFFF, 32'h0000_FFFF);
    sample_at(32'h0001_0001, 32'h0000_8000);
    sample_at(32'hFFFF_8000, 32'hFFFE_0000);
    sample_at(32'h0003_0000, 32'hFFFD_0000);
    put_texel(32, 0, 24'h5AA53C);
    sample_at(32'h0000_8000, 32'h0000_0000);
    wait_idle();

    set_sizes(9'd1, 9'd1);
    run_phase(PHASE_ITEMS);
    wait_idle();

    calm = 1'b1;
    set_sizes(9'd256, 9'd256);
    run_phase(PHASE_ITEMS);
    wait_idle();
    calm = 1'b0;

    set_sizes(9'd0, 9'd511);
    run_phase(PHASE_ITEMS);
    wait_idle();

    set_sizes(9'd511, 9'd0);
    run_phase(PHASE_ITEMS);
    wait_idle();

    // The output side stalls for a long stretch while requests keep coming.
    set_sizes(9'd5, 9'd200);
    hold_go = 1'b1;
    run_phase(60);
    wait_idle();
    run_phase(50);
    wait_idle();

    set_sizes(CFG_W'($urandom_range(1, 256)), CFG_W'($urandom_range(1, 256)));
    run_phase(PHASE_ITEMS);
    wait_idle();

    set_sizes(CFG_W'($urandom_range(257, 511)), 9'd2);
    run_phase(PHASE_ITEMS);
    wait_idle();

    set_sizes(9'd64, 9'd3);
    run_phase(PHASE_ITEMS);
    wait_idle();

    if (board.errors == 0) begin
      $display("repeat_wrap_nearest_texture_sampler_tb OK");
    end else begin
      $display("repeat_wrap_nearest_texture_sampler_tb NOT OK");
    end
    $finish;
  end

endmodule
